// ----- rtl/core/wwdg_pkg.sv -----
package wwdg_pkg;

    // request types
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // register offsets
    localparam logic [11:0] ADDR_CR  = 12'h000;
    localparam logic [11:0] ADDR_IR  = 12'h004;
    localparam logic [11:0] ADDR_TO  = 12'h008;
    localparam logic [11:0] ADDR_WN  = 12'h00C;
    localparam logic [11:0] ADDR_SR  = 12'h010;
    localparam logic [11:0] ADDR_CO  = 12'h014;
    localparam logic [11:0] ADDR_SK  = 12'h018;
    localparam logic [11:0] ADDR_RRR = 12'h01C;

    // control word bits
    localparam int CR_WEN = 0;
    localparam int CR_SLK = 4;
    localparam int CR_ITR = 6;
    localparam int CR_WND = 7;
    localparam logic [1:0] SMD_KEYED = 2'b01;

    // service register codes
    localparam logic [31:0] CODE_UNLOCK_A = 32'h0000_C520;
    localparam logic [31:0] CODE_UNLOCK_B = 32'h0000_D928;
    localparam logic [31:0] CODE_SERVE_A  = 32'h0000_A602;
    localparam logic [31:0] CODE_SERVE_B  = 32'h0000_B480;

    // unlock sequence steps
    localparam logic [1:0] UNLOCK_IDLE = 2'd0;
    localparam logic [1:0] UNLOCK_HALF = 2'd1;
    localparam logic [1:0] UNLOCK_DONE = 2'd2;

    // reset values
    localparam logic [31:0] RST_CONTROL = 32'hFF00_010A;
    localparam logic [31:0] RST_TIMEOUT = 32'h0000_0320;
    localparam logic [15:0] RST_KEY     = 16'h0100;
    localparam logic [7:0]  RST_REASON  = 8'hFF;

    // keyed service: next = key * 17 + 3
    localparam logic [15:0] KEY_STEP = 16'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] address;
        logic [31:0] write_data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
        logic        reset_request;
    } result_t;

endpackage

// ----- rtl/core/wwdg_req_if.sv -----
interface wwdg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [11:0] address;
    logic [31:0] write_data;

    modport source (output valid, output req_type, output address, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input address, input write_data,
                    output ready);
endinterface

// ----- rtl/core/wwdg_rsp_if.sv -----
interface wwdg_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq_level;
    logic        reset_request;

    modport source (output valid, output read_data, output irq_level, output reset_request,
                    input ready);
    modport sink   (input valid, input read_data, input irq_level, input reset_request,
                    output ready);
endinterface

// ----- rtl/core/windowed_watchdog_with_keyed_service.sv -----
// Channel  Dir  Payload                                   Transfer
// req      in   req_type[1:0] address[11:0] write_data    valid && ready
// rsp      out  read_data[31:0] irq_level reset_request   valid && ready
// cfg      in   cfg_wdata (timeout reset enable)          cfg_we
//
// One item per clock sustained while rsp is not stalled: request register, then the watchdog
// state update and result register. The request register holds each item until
// the result register can take its result.
// The combinational state update sets this rate.
// Reset is asynchronous; all watchdog state returns to its power-on values.
// A stalled rsp holds its result; req keeps taking one item while the
// result register is full, then backpressures.
module windowed_watchdog_with_keyed_service
(
    input  logic        clk,
    input  logic        rst_n,
    wwdg_req_if.sink    req,
    wwdg_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    wwdg_pkg::item_t   item_reg;
    logic              item_valid_reg;
    wwdg_pkg::result_t out_reg;
    logic              out_valid_reg;
    logic              rot_reg;
    wwdg_pkg::result_t core_result;
    logic              advance;

    // request moves into the core when the result register can take it
    assign advance   = item_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            rot_reg        <= 1'b0;
        end
        else
        begin
            if (req.ready)
                item_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg_we)
                rot_reg <= cfg_wdata;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.req_type   <= req.req_type;
            item_reg.address    <= req.address;
            item_reg.write_data <= req.write_data;
        end
        if (advance)
            out_reg <= core_result;
    end

    wwdg_core u_core
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .item             (item_reg),
        .timeout_reset_en (rot_reg),
        .result           (core_result)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_reg.read_data;
    assign rsp.irq_level     = out_reg.irq_level;
    assign rsp.reset_request = out_reg.reset_request;

endmodule

// ----- rtl/core/wwdg_core.sv -----
module wwdg_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  wwdg_pkg::item_t  item,
    input  logic             timeout_reset_en,
    output wwdg_pkg::result_t result
);

    logic [31:0] control_word_reg,  control_word_next;
    logic        timeout_flag_reg,  timeout_flag_next;
    logic [31:0] timeout_value_reg, timeout_value_next;
    logic [31:0] window_value_reg,  window_value_next;
    logic [15:0] service_key_reg,   service_key_next;
    logic [7:0]  reset_reason_reg,  reset_reason_next;
    logic [1:0]  unlock_step_reg,   unlock_step_next;
    logic        service_step_reg,  service_step_next;
    logic [31:0] down_count_reg,    down_count_next;
    logic        counting_reg,      counting_next;

    logic [15:0] key_calc;
    logic [31:0] reload_value;
    logic        locked;
    logic        keyed;
    logic [31:0] dec_count;
    logic        fixed_ok;

    assign key_calc     = (service_key_reg << 4) + service_key_reg + wwdg_pkg::KEY_STEP;
    assign locked       = control_word_reg[wwdg_pkg::CR_SLK]
                          && (unlock_step_reg != wwdg_pkg::UNLOCK_DONE);
    assign keyed        = (control_word_reg[10:9] == wwdg_pkg::SMD_KEYED);
    assign reload_value = (timeout_value_reg == 32'd0) ? 32'd1 : timeout_value_reg;
    assign dec_count    = (down_count_reg != 32'd0) ? down_count_reg - 32'd1 : down_count_reg;
    // fixed-mode second word outside the window is dropped
    assign fixed_ok     = !(control_word_reg[wwdg_pkg::CR_WND]
                            && (down_count_reg > window_value_reg));

    always_comb
    begin
        control_word_next  = control_word_reg;
        timeout_flag_next  = timeout_flag_reg;
        timeout_value_next = timeout_value_reg;
        window_value_next  = window_value_reg;
        service_key_next   = service_key_reg;
        reset_reason_next  = reset_reason_reg;
        unlock_step_next   = unlock_step_reg;
        service_step_next  = service_step_reg;
        down_count_next    = down_count_reg;
        counting_next      = counting_reg;
        result             = '0;

        if (step)
        begin
            case (item.req_type)
                wwdg_pkg::REQ_READ:
                begin
                    case (item.address)
                        wwdg_pkg::ADDR_CR:  result.read_data = control_word_reg;
                        wwdg_pkg::ADDR_IR:  result.read_data = {31'd0, timeout_flag_reg};
                        wwdg_pkg::ADDR_TO:  result.read_data = timeout_value_reg;
                        wwdg_pkg::ADDR_WN:  result.read_data = window_value_reg;
                        wwdg_pkg::ADDR_CO:  result.read_data = down_count_reg;
                        wwdg_pkg::ADDR_SK:
                            result.read_data = keyed ? {16'd0, service_key_reg} : 32'd0;
                        wwdg_pkg::ADDR_RRR: result.read_data = {24'd0, reset_reason_reg};
                        default:            result.read_data = 32'd0;
                    endcase
                end
                wwdg_pkg::REQ_WRITE:
                begin
                    case (item.address)
                        wwdg_pkg::ADDR_CR:
                        begin
                            if (!locked)
                            begin
                                control_word_next = item.write_data;
                                unlock_step_next  = wwdg_pkg::UNLOCK_IDLE;
                                counting_next     = item.write_data[wwdg_pkg::CR_WEN];
                                if (item.write_data[wwdg_pkg::CR_WEN])
                                    down_count_next = reload_value;
                            end
                        end
                        wwdg_pkg::ADDR_IR:
                        begin
                            if (item.write_data[0])
                                timeout_flag_next = 1'b0;
                        end
                        wwdg_pkg::ADDR_TO:
                        begin
                            if (!locked)
                            begin
                                timeout_value_next = item.write_data;
                                counting_next      = control_word_reg[wwdg_pkg::CR_WEN];
                                if (control_word_reg[wwdg_pkg::CR_WEN])
                                    down_count_next = (item.write_data == 32'd0) ? 32'd1
                                                                                 : item.write_data;
                            end
                        end
                        wwdg_pkg::ADDR_WN:
                        begin
                            if (!locked)
                                window_value_next = item.write_data;
                        end
                        wwdg_pkg::ADDR_SR:
                        begin
                            if (item.write_data == wwdg_pkg::CODE_UNLOCK_A
                                && unlock_step_reg == wwdg_pkg::UNLOCK_IDLE)
                            begin
                                unlock_step_next = wwdg_pkg::UNLOCK_HALF;
                            end
                            else if (item.write_data == wwdg_pkg::CODE_UNLOCK_B
                                     && unlock_step_reg == wwdg_pkg::UNLOCK_HALF)
                            begin
                                unlock_step_next = wwdg_pkg::UNLOCK_DONE;
                                control_word_next[wwdg_pkg::CR_SLK] = 1'b0;
                            end

                            if (keyed)
                            begin
                                if (item.write_data == {16'd0, key_calc})
                                begin
                                    service_key_next = key_calc;
                                    if (service_step_reg)
                                    begin
                                        service_step_next = 1'b0;
                                        timeout_flag_next = 1'b0;
                                        counting_next = control_word_reg[wwdg_pkg::CR_WEN];
                                        if (control_word_reg[wwdg_pkg::CR_WEN])
                                            down_count_next = reload_value;
                                    end
                                    else
                                    begin
                                        service_step_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    service_step_next = 1'b0;
                                end
                            end
                            else if (item.write_data == wwdg_pkg::CODE_SERVE_A
                                     && !service_step_reg)
                            begin
                                service_step_next = 1'b1;
                            end
                            else if (item.write_data == wwdg_pkg::CODE_SERVE_B
                                     && service_step_reg)
                            begin
                                service_step_next = 1'b0;
                                if (fixed_ok)
                                begin
                                    timeout_flag_next = 1'b0;
                                    counting_next = control_word_reg[wwdg_pkg::CR_WEN];
                                    if (control_word_reg[wwdg_pkg::CR_WEN])
                                        down_count_next = reload_value;
                                end
                            end
                            else if (item.write_data != wwdg_pkg::CODE_SERVE_A
                                     && item.write_data != wwdg_pkg::CODE_SERVE_B
                                     && item.write_data != wwdg_pkg::CODE_UNLOCK_A
                                     && item.write_data != wwdg_pkg::CODE_UNLOCK_B)
                            begin
                                // stray word aborts both sequences
                                service_step_next = 1'b0;
                                unlock_step_next  = wwdg_pkg::UNLOCK_IDLE;
                            end
                        end
                        wwdg_pkg::ADDR_RRR:
                        begin
                            reset_reason_next = reset_reason_reg & ~item.write_data[7:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                wwdg_pkg::REQ_TICK:
                begin
                    if (counting_reg)
                    begin
                        down_count_next = dec_count;
                        if (dec_count == 32'd0)
                        begin
                            timeout_flag_next    = 1'b1;
                            result.reset_request = !control_word_reg[wwdg_pkg::CR_ITR]
                                                   && timeout_reset_en;
                            counting_next        = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            result.irq_level = timeout_flag_next && control_word_next[wwdg_pkg::CR_ITR];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_word_reg  <= wwdg_pkg::RST_CONTROL;
            timeout_flag_reg  <= 1'b0;
            timeout_value_reg <= wwdg_pkg::RST_TIMEOUT;
            window_value_reg  <= 32'd0;
            service_key_reg   <= wwdg_pkg::RST_KEY;
            reset_reason_reg  <= wwdg_pkg::RST_REASON;
            unlock_step_reg   <= wwdg_pkg::UNLOCK_IDLE;
            service_step_reg  <= 1'b0;
            down_count_reg    <= 32'd0;
            counting_reg      <= 1'b0;
        end
        else
        begin
            control_word_reg  <= control_word_next;
            timeout_flag_reg  <= timeout_flag_next;
            timeout_value_reg <= timeout_value_next;
            window_value_reg  <= window_value_next;
            service_key_reg   <= service_key_next;
            reset_reason_reg  <= reset_reason_next;
            unlock_step_reg   <= unlock_step_next;
            service_step_reg  <= service_step_next;
            down_count_reg    <= down_count_next;
            counting_reg      <= counting_next;
        end
    end

    // a running countdown never sits at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        counting_reg |-> (down_count_reg != 32'd0))
        else $error("counting with zero count");

    // flag only rises on a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(timeout_flag_reg) |-> $past(step && item.req_type == wwdg_pkg::REQ_TICK))
        else $error("timeout flag set outside a tick");

    // reset request and interrupt are exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        result.reset_request |-> !result.irq_level)
        else $error("reset request with interrupt mode on");

    // stopping on timeout clears counting on the next edge
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.reset_request) |=> !counting_reg && timeout_flag_reg)
        else $error("timeout did not stop the countdown");

endmodule

// ----- sim/tb_windowed_watchdog_with_keyed_service.sv -----
`timescale 1ns / 100ps

module tb_windowed_watchdog_with_keyed_service;

    // request type 3 is not decoded; the block answers it with zero read data and no reset request
    localparam logic [1:0]  REQ_NONE  = 2'd3;
    // highest byte offset, far outside the register map
    localparam logic [11:0] ADDR_TOP  = 12'hFFF;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    // control word values used by the directed table
    localparam logic [31:0] CR_RUN_LOCKED_IRQ = 32'h0000_0051;   // enable, soft lock, irq mode
    localparam logic [31:0] CR_RUN_KEYED      = 32'h0000_0201;   // enable, keyed service
    localparam logic [31:0] SR_BAD_WORD       = 32'h1234_5678;
    // first two keys of the keyed service chain starting from the reset key
    localparam logic [31:0] KEY_FIRST         = 32'h0000_1103;
    localparam logic [31:0] KEY_SECOND        = 32'h0000_2136;

    localparam bit          TYPED    = 1'b1;   // expected result spelled out in the table
    localparam bit          PRED     = 1'b0;   // expected result from the predictor
    localparam logic [33:0] ZERO_RSP = 34'h0;

    localparam int DIR_ROWS     = 26;
    localparam int PHASE_ITEMS  = 256;
    localparam int DRAIN_CYCLES = 6;           // margin after the last expected result

    typedef struct packed {
        wwdg_pkg::item_t   it;
        bit                typed;
        wwdg_pkg::result_t want;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    wwdg_req_if req_bus ();
    wwdg_rsp_if rsp_bus ();

    windowed_watchdog_with_keyed_service i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Clock, global timeout
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #5000000;
        $display("FAIL windowed_watchdog_with_keyed_service");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor state: a shadow copy of every watchdog register
    // ------------------------------------------------------------------
    logic [31:0] m_ctrl;
    logic [31:0] m_tmo;
    logic [31:0] m_win;
    logic [31:0] m_count;
    logic [15:0] m_key;
    logic [7:0]  m_reason;
    logic [1:0]  m_ulk;
    logic        m_svc_step;
    logic        m_flag;
    logic        m_run;
    logic        m_to_rst_en;

    function automatic logic [15:0] key_after(input logic [15:0] k);
        return k * 16'd17 + wwdg_pkg::KEY_STEP;
    endfunction

    function automatic logic keyed_mode();
        return m_ctrl[10:9] == wwdg_pkg::SMD_KEYED;
    endfunction

    function automatic logic soft_locked();
        return m_ctrl[wwdg_pkg::CR_SLK] && m_ulk != wwdg_pkg::UNLOCK_DONE;
    endfunction

    // reload the countdown, or stop it when the enable bit is clear
    function automatic void rearm_countdown();
        if (m_ctrl[wwdg_pkg::CR_WEN])
        begin
            m_count = (m_tmo != 32'd0) ? m_tmo : 32'd1;
            m_run   = 1'b1;
        end
        else
        begin
            m_run = 1'b0;
        end
    endfunction

    function automatic void predictor_reset();
        m_ctrl      = wwdg_pkg::RST_CONTROL;
        m_tmo       = wwdg_pkg::RST_TIMEOUT;
        m_win       = 32'd0;
        m_key       = wwdg_pkg::RST_KEY;
        m_reason    = wwdg_pkg::RST_REASON;
        m_ulk       = wwdg_pkg::UNLOCK_IDLE;
        m_svc_step  = 1'b0;
        m_flag      = 1'b0;
        m_count     = 32'd0;
        m_run       = 1'b0;
        m_to_rst_en = 1'b0;
        rearm_countdown();
    endfunction

    // write to the service register: unlock words first, then service
    function automatic void service_write(input logic [31:0] v);
        logic [15:0] nk;
        nk = key_after(m_key);
        if (v == wwdg_pkg::CODE_UNLOCK_A && m_ulk == wwdg_pkg::UNLOCK_IDLE)
        begin
            m_ulk = wwdg_pkg::UNLOCK_HALF;
        end
        else if (v == wwdg_pkg::CODE_UNLOCK_B && m_ulk == wwdg_pkg::UNLOCK_HALF)
        begin
            m_ulk                    = wwdg_pkg::UNLOCK_DONE;
            m_ctrl[wwdg_pkg::CR_SLK] = 1'b0;
        end

        if (keyed_mode())
        begin
            // two matching keys in a row service; window rules do not apply
            if (v == {16'h0, nk})
            begin
                m_key = nk;
                if (m_svc_step)
                begin
                    m_svc_step = 1'b0;
                    m_flag     = 1'b0;
                    rearm_countdown();
                end
                else
                begin
                    m_svc_step = 1'b1;
                end
            end
            else
            begin
                m_svc_step = 1'b0;
            end
        end
        else if (v == wwdg_pkg::CODE_SERVE_A && !m_svc_step)
        begin
            m_svc_step = 1'b1;
        end
        else if (v == wwdg_pkg::CODE_SERVE_B && m_svc_step)
        begin
            m_svc_step = 1'b0;
            // too early in window mode: the second word is dropped
            if (!(m_ctrl[wwdg_pkg::CR_WND] && m_count > m_win))
            begin
                m_flag = 1'b0;
                rearm_countdown();
            end
        end
        else if (v != wwdg_pkg::CODE_SERVE_A && v != wwdg_pkg::CODE_SERVE_B &&
                 v != wwdg_pkg::CODE_UNLOCK_A && v != wwdg_pkg::CODE_UNLOCK_B)
        begin
            m_svc_step = 1'b0;
            m_ulk      = wwdg_pkg::UNLOCK_IDLE;
        end
    endfunction

    // one item in, one result out; updates the shadow state
    function automatic wwdg_pkg::result_t watchdog_predict(input wwdg_pkg::item_t it);
        wwdg_pkg::result_t r;
        r = '0;
        case (it.req_type)
            wwdg_pkg::REQ_READ:
            begin
                case (it.address)
                    wwdg_pkg::ADDR_CR:  r.read_data = m_ctrl;
                    wwdg_pkg::ADDR_IR:  r.read_data = {31'h0, m_flag};
                    wwdg_pkg::ADDR_TO:  r.read_data = m_tmo;
                    wwdg_pkg::ADDR_WN:  r.read_data = m_win;
                    wwdg_pkg::ADDR_CO:  r.read_data = m_count;
                    wwdg_pkg::ADDR_SK:  r.read_data = keyed_mode() ? {16'h0, m_key} : 32'h0;
                    wwdg_pkg::ADDR_RRR: r.read_data = {24'h0, m_reason};
                    default:            r.read_data = 32'h0;
                endcase
            end
            wwdg_pkg::REQ_WRITE:
            begin
                case (it.address)
                    wwdg_pkg::ADDR_CR:
                    begin
                        if (!soft_locked())
                        begin
                            m_ctrl = it.write_data;
                            m_ulk  = wwdg_pkg::UNLOCK_IDLE;
                            rearm_countdown();
                        end
                    end
                    wwdg_pkg::ADDR_IR:
                    begin
                        if (it.write_data[0])
                            m_flag = 1'b0;
                    end
                    wwdg_pkg::ADDR_TO:
                    begin
                        if (!soft_locked())
                        begin
                            m_tmo = it.write_data;
                            rearm_countdown();
                        end
                    end
                    wwdg_pkg::ADDR_WN:
                    begin
                        if (!soft_locked())
                            m_win = it.write_data;
                    end
                    wwdg_pkg::ADDR_SR:  service_write(it.write_data);
                    wwdg_pkg::ADDR_RRR: m_reason = m_reason & ~it.write_data[7:0];
                    default:            ;
                endcase
            end
            wwdg_pkg::REQ_TICK:
            begin
                if (m_run)
                begin
                    if (m_count != 32'd0)
                        m_count = m_count - 32'd1;
                    if (m_count == 32'd0)
                    begin
                        m_flag = 1'b1;
                        if (!m_ctrl[wwdg_pkg::CR_ITR] && m_to_rst_en)
                            r.reset_request = 1'b1;
                        m_run = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        r.irq_level = m_flag & m_ctrl[wwdg_pkg::CR_ITR];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table: reset values, extremes, odd request types, then the
    // lock / unlock / fixed service / keyed service paths in order
    // ------------------------------------------------------------------
    row_t dir_tbl [DIR_ROWS] = '{
        // register file straight after reset
        {wwdg_pkg::REQ_READ, wwdg_pkg::ADDR_CR, 32'h0, TYPED, wwdg_pkg::RST_CONTROL, 2'b00},
        {wwdg_pkg::REQ_READ, wwdg_pkg::ADDR_IR, 32'h0, TYPED, 32'h0, 2'b00},
        {wwdg_pkg::REQ_READ, wwdg_pkg::ADDR_TO, 32'h0, TYPED, wwdg_pkg::RST_TIMEOUT, 2'b00},
        {wwdg_pkg::REQ_READ, wwdg_pkg::ADDR_CO, 32'h0, TYPED, 32'h0, 2'b00},
        {wwdg_pkg::REQ_READ, wwdg_pkg::ADDR_SK, 32'h0, TYPED, 32'h0, 2'b00},
        {wwdg_pkg::REQ_READ, wwdg_pkg::ADDR_RRR, 32'h0, TYPED,
         {24'h0, wwdg_pkg::RST_REASON}, 2'b00},
        // unknown offset, undecoded request type, tick while stopped
        {wwdg_pkg::REQ_READ, ADDR_TOP, ALL_ONES, TYPED, 32'h0, 2'b00},
        {REQ_NONE,           ADDR_TOP, ALL_ONES, TYPED, 32'h0, 2'b00},
        {wwdg_pkg::REQ_TICK, ADDR_TOP, ALL_ONES, TYPED, 32'h0, 2'b00},
        // zero timeout counts as one: the next tick times out with irq
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_TO, 32'h0, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_CR, CR_RUN_LOCKED_IRQ, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_TICK,  wwdg_pkg::ADDR_CR, 32'h0, PRED, ZERO_RSP},
        // counter write has no effect; locked timeout write is dropped
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_CO, ALL_ONES, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_TO, 32'h5, PRED, ZERO_RSP},
        // unlock, then the timeout write goes through
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR, wwdg_pkg::CODE_UNLOCK_A, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR, wwdg_pkg::CODE_UNLOCK_B, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_TO, 32'h3, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_IR, ALL_ONES, PRED, ZERO_RSP},
        // invalid service word, then a fixed two-word service
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR, SR_BAD_WORD, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR, wwdg_pkg::CODE_SERVE_A, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR, wwdg_pkg::CODE_SERVE_B, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_RRR, ALL_ONES, PRED, ZERO_RSP},
        // keyed mode: key is visible, two chained keys service
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_CR, CR_RUN_KEYED, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_READ,  wwdg_pkg::ADDR_SK, 32'h0, TYPED,
         {16'h0, wwdg_pkg::RST_KEY}, 2'b00},
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR, KEY_FIRST, PRED, ZERO_RSP},
        {wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR, KEY_SECOND, PRED, ZERO_RSP}
    };

    // ------------------------------------------------------------------
    // Response side: random stall, compare against the oldest expectation
    // ------------------------------------------------------------------
    wwdg_pkg::result_t expected_rsp [$];
    wwdg_pkg::result_t rsp_want;
    int      send_gap_pct;
    int      rsp_stall_pct;
    int      n_errors;
    int      n_sent;
    int      n_checked;
    int      n_irq_seen;
    int      n_rst_pulses;

    always @(negedge clk)
        rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        n_errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                $display("%0t: result with nothing expected, got rd=%h irq=%b rst=%b",
                         $time, rsp_bus.read_data, rsp_bus.irq_level,
                         rsp_bus.reset_request);
                n_errors++;
            end
            else
            begin
                rsp_want = expected_rsp.pop_front();
                n_checked++;
                if (rsp_bus.irq_level === 1'b1)
                    n_irq_seen++;
                if (rsp_bus.reset_request === 1'b1)
                    n_rst_pulses++;
                if (rsp_bus.read_data !== rsp_want.read_data)
                    report_field("read_data", rsp_want.read_data, rsp_bus.read_data);
                if (rsp_bus.irq_level !== rsp_want.irq_level)
                    report_field("irq_level", {31'h0, rsp_want.irq_level},
                                 {31'h0, rsp_bus.irq_level});
                if (rsp_bus.reset_request !== rsp_want.reset_request)
                    report_field("reset_request", {31'h0, rsp_want.reset_request},
                                 {31'h0, rsp_bus.reset_request});
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one item at a falling edge and hold it until the transfer.
    // The expectation is logged at the transfer, so state is always current.
    task automatic send_item(input wwdg_pkg::item_t it, input bit typed,
                             input wwdg_pkg::result_t want);
        wwdg_pkg::result_t got;
        while ($urandom_range(99) < send_gap_pct)
        begin
            @(negedge clk);
            req_bus.valid = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        req_bus.valid      = 1'b1;
        req_bus.req_type   = it.req_type;
        req_bus.address    = it.address;
        req_bus.write_data = it.write_data;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        got = watchdog_predict(it);
        expected_rsp.push_back(typed ? want : got);
        n_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        @(negedge clk);
        req_bus.valid = 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // config write only while the pipeline is empty
    task automatic write_timeout_reset_en(input logic v);
        drain_results();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
        m_to_rst_en = v;
    endtask

    // ------------------------------------------------------------------
    // Random sequences. Mostly well-formed: tick bursts against small
    // timeouts, unlock pairs, fixed and keyed service pairs built from the
    // current key; the rest is noise, broken pairs and stray offsets.
    // ------------------------------------------------------------------
    wwdg_pkg::item_t planned [$];

    function automatic wwdg_pkg::item_t mk(input logic [1:0] rt, input logic [11:0] a,
                                           input logic [31:0] d);
        wwdg_pkg::item_t it;
        it.req_type   = rt;
        it.address    = a;
        it.write_data = d;
        return it;
    endfunction

    function automatic void plan_sequence();
        int          pick;
        int          n;
        int          flip;
        logic [31:0] v;
        logic [15:0] k1;
        logic [15:0] k2;
        pick = $urandom_range(99);
        if (pick < 25)
        begin
            n = $urandom_range(1, 12);
            repeat (n) planned.push_back(mk(wwdg_pkg::REQ_TICK, 12'($urandom), $urandom));
        end
        else if (pick < 35)
        begin
            planned.push_back(mk(wwdg_pkg::REQ_READ, 12'($urandom_range(7) * 4), $urandom));
        end
        else if (pick < 45)
        begin
            v                    = $urandom;
            v[wwdg_pkg::CR_WEN]  = ($urandom_range(9) != 0);
            v[wwdg_pkg::CR_SLK]  = ($urandom_range(3) == 0);
            if ($urandom_range(1))
                v[10:9] = wwdg_pkg::SMD_KEYED;
            planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_CR, v));
        end
        else if (pick < 53)
        begin
            v = ($urandom_range(7) == 0) ? $urandom : $urandom_range(24);
            planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_TO, v));
        end
        else if (pick < 58)
        begin
            v = ($urandom_range(7) == 0) ? $urandom : $urandom_range(24);
            planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_WN, v));
        end
        else if (pick < 66)
        begin
            planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR,
                                 wwdg_pkg::CODE_UNLOCK_A));
            if ($urandom_range(4) != 0)
                planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR,
                                     wwdg_pkg::CODE_UNLOCK_B));
            else
                planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_TO,
                                     32'($urandom_range(24))));
        end
        else if (pick < 76)
        begin
            planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR,
                                 wwdg_pkg::CODE_SERVE_A));
            if ($urandom_range(3) == 0)
                planned.push_back(mk(wwdg_pkg::REQ_TICK, wwdg_pkg::ADDR_CR, 32'h0));
            planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR,
                                 wwdg_pkg::CODE_SERVE_B));
        end
        else if (pick < 86)
        begin
            k1 = key_after(m_key);
            k2 = key_after(k1);
            if ($urandom_range(5) == 0)
            begin
                flip     = $urandom_range(15);
                k2[flip] = ~k2[flip];
            end
            planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR, {16'h0, k1}));
            planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR, {16'h0, k2}));
            if ($urandom_range(1))
                planned.push_back(mk(wwdg_pkg::REQ_READ, wwdg_pkg::ADDR_SK, 32'h0));
        end
        else if (pick < 90)
        begin
            planned.push_back(mk(wwdg_pkg::REQ_WRITE,
                                 $urandom_range(1) ? wwdg_pkg::ADDR_IR : wwdg_pkg::ADDR_RRR,
                                 $urandom));
        end
        else if (pick < 94)
        begin
            planned.push_back(mk($urandom_range(1) ? wwdg_pkg::REQ_READ : wwdg_pkg::REQ_WRITE,
                                 12'($urandom), $urandom));
        end
        else if (pick < 97)
        begin
            planned.push_back(mk(REQ_NONE, 12'($urandom), $urandom));
        end
        else
        begin
            planned.push_back(mk(wwdg_pkg::REQ_WRITE, wwdg_pkg::ADDR_SR, $urandom));
        end
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_flow
        wwdg_pkg::item_t it;
        int    counted;
        bit    paused;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.req_type   = wwdg_pkg::REQ_READ;
        req_bus.address    = 12'h0;
        req_bus.write_data = 32'h0;
        send_gap_pct       = 0;
        rsp_stall_pct      = 0;
        n_errors           = 0;
        n_sent             = 0;
        n_checked          = 0;
        n_irq_seen         = 0;
        n_rst_pulses       = 0;
        predictor_reset();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_timeout_reset_en(1'b0);
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_tbl[i].it, dir_tbl[i].typed, dir_tbl[i].want);

        // phase 0 no gaps, 1 sender gaps, 2 receiver stalls, 3 light both;
        // the timeout reset enable alternates so both settings see timeouts
        for (int ph = 0; ph < 4; ph++)
        begin
            write_timeout_reset_en((ph % 2) == 0);
            case (ph)
                0:       begin send_gap_pct = 0;  rsp_stall_pct = 0;  end
                1:       begin send_gap_pct = 79; rsp_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  rsp_stall_pct = 79; end
                default: begin send_gap_pct = 7;  rsp_stall_pct = 7;  end
            endcase
            counted = 0;
            paused  = 1'b0;
            while (counted < PHASE_ITEMS)
            begin
                if (planned.size() == 0)
                    plan_sequence();
                it = planned.pop_front();
                send_item(it, PRED, ZERO_RSP);
                if (it.req_type != REQ_NONE)
                    counted++;
                // mid-run hold: sender waits for the pipeline to empty
                if (ph == 1 && !paused && counted >= PHASE_ITEMS / 2)
                begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        $display("Sent %0d items (directed table plus four random gap/stall phases, ",
                 n_sent);
        $display("  timeout reset off and on): %0d checked, %0d with irq, %0d reset pulses",
                 n_checked, n_irq_seen, n_rst_pulses);
        if (n_errors == 0)
            $display("PASS windowed_watchdog_with_keyed_service");
        else
            $display("FAIL windowed_watchdog_with_keyed_service");
        $finish;
    end

endmodule
